### hdl/dcrc_pkg.sv
package dcrc_pkg;

  // Default sizes of the pending queue and of the longest datagram.
  localparam int QueueDepthDefault  = 16;
  localparam int MaxDatagramDefault = 2048;

  // Reset values of the configuration registers.
  localparam logic [4:0]  MAX_NAME_RESET    = 5'd20;
  localparam logic [10:0] MAX_CONTENT_RESET = 11'd1400;

  // Largest content length that the result reports.
  localparam logic [10:0] CONTENT_SAT = 11'd2047;

  // Configuration register indexes.
  localparam logic REG_MAX_NAME    = 1'b0;
  localparam logic REG_MAX_CONTENT = 1'b1;

  // Message type codes.
  localparam logic [7:0] T_CONFIRM = 8'h00;
  localparam logic [7:0] T_REPLY   = 8'h01;
  localparam logic [7:0] T_MSG     = 8'h04;
  localparam logic [7:0] T_ERR     = 8'hFE;
  localparam logic [7:0] T_BYE     = 8'hFF;

  // Printable character range for names and content.
  localparam logic [7:0] CHAR_LOW  = 8'h20;
  localparam logic [7:0] CHAR_HIGH = 8'h7E;

  // Reply status byte that means success.
  localparam logic [7:0] REPLY_OK = 8'h01;

  // Action codes reported with each result.
  typedef enum logic [3:0] {
    ACT_CONFIRM_OK   = 4'd0,
    ACT_CONFIRM_MISS = 4'd1,
    ACT_REPLY_OK     = 4'd2,
    ACT_REPLY_FAIL   = 4'd3,
    ACT_MSG_OK       = 4'd4,
    ACT_TOO_SHORT    = 4'd5,
    ACT_BAD_NAME     = 4'd6,
    ACT_TOO_LONG     = 4'd7,
    ACT_BAD_CONTENT  = 4'd8,
    ACT_ERR          = 4'd9,
    ACT_BYE          = 4'd10,
    ACT_UNKNOWN      = 4'd11
  } action_t;

  // One input item.
  typedef struct packed {
    logic        mode;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] sent_id;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  msg_type;
    logic [15:0] ref_id;
    logic [3:0]  action;
    logic        send_confirm;
    logic        send_error;
    logic        quit;
    logic [4:0]  pending_count;
    logic [4:0]  name_length;
    logic [10:0] body_length;
  } result_t;

endpackage

### hdl/datagram_chat_receive_classifier.sv
// Datagram bytes and ID registrations are taken one item per cycle while item_stall is low.
// A result is loaded into the output register at the edge that takes a datagram's last byte,
// except for a confirm, whose queue search and removal run on one memory port first,
// through the read, compare, shift and emit states, with no item taken meanwhile.
// Reset (rst, synchronous) empties the pending queue, clears the datagram in progress
// and loads the configuration registers with their defaults.
module datagram_chat_receive_classifier
  import dcrc_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QueueDepthDefault,
  parameter int MAX_DATAGRAM = MaxDatagramDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int BW = $clog2(MAX_DATAGRAM + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SREAD,
    S_SWRITE,
    S_EMIT
  } state_t;

  function automatic logic printable(input logic [7:0] b);
    printable = (b >= CHAR_LOW) && (b <= CHAR_HIGH);
  endfunction

  state_t        state;
  logic [4:0]    max_name;
  logic [10:0]   max_content;

  logic [BW-1:0] byte_index;
  logic [7:0]    type_reg;
  logic [15:0]   ref_reg;
  logic [7:0]    reply_result;
  logic [4:0]    name_len_reg;
  logic          f_closed, f_nfault, f_cfault, f_cended;

  logic [CW-1:0] fill;
  logic [CW-1:0] idx;
  logic [CW:0]   idx_inc;
  result_t       res;
  result_t       emit_res;

  logic [15:0]   pending_ids [QUEUE_DEPTH];
  logic [15:0]   rd_data;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [15:0]   wr_data;

  logic          accept;
  logic          out_free;
  logic          result_load;

  logic [BW-1:0] byte_index_next;
  logic [7:0]    type_next;
  logic [15:0]   ref_next;
  logic [7:0]    reply_next;
  logic [4:0]    name_len_next;
  logic          closed_next, nfault_next, cfault_next, cended_next;
  result_t       cls;
  logic [BW:0]   name_end;
  logic [BW:0]   content_raw;
  logic [10:0]   content_len;

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE) ||
                      (result_valid && result_stall && !item.mode && item.last_byte);
  assign accept     = item_valid && !item_stall;
  assign idx_inc    = {1'b0, idx} + (CW+1)'(1);

  // A new result enters the output register at this edge.
  assign result_load = (state == S_IDLE && accept && !item.mode && item.last_byte &&
                        type_next != T_CONFIRM) || (state == S_EMIT && out_free);

  // Datagram state after the current byte.
  always_comb begin
    byte_index_next = byte_index;
    type_next       = type_reg;
    ref_next        = ref_reg;
    reply_next      = reply_result;
    name_len_next   = name_len_reg;
    closed_next     = f_closed;
    nfault_next     = f_nfault;
    cfault_next     = f_cfault;
    cended_next     = f_cended;
    if (byte_index < BW'(MAX_DATAGRAM)) begin
      if (byte_index == BW'(0)) begin
        type_next = item.data_byte;
      end else if (byte_index == BW'(1)) begin
        ref_next = {item.data_byte, 8'h00};
      end else if (byte_index == BW'(2)) begin
        ref_next = {ref_reg[15:8], item.data_byte};
      end
      if (byte_index == BW'(3)) begin
        reply_next = item.data_byte;
      end
      if (byte_index >= BW'(3) && type_reg == T_MSG) begin
        if (!f_closed) begin
          if (item.data_byte == 8'h00) begin
            closed_next = 1'b1;
          end else if (name_len_reg >= max_name) begin
            closed_next = 1'b1;
            nfault_next = 1'b1;
          end else begin
            if (!printable(item.data_byte)) begin
              nfault_next = 1'b1;
            end
            name_len_next = name_len_reg + 5'd1;
          end
        end else if (!f_cfault && !f_cended) begin
          if (item.data_byte == 8'h00) begin
            cended_next = 1'b1;
          end else if (!printable(item.data_byte)) begin
            cfault_next = 1'b1;
          end
        end
      end
      byte_index_next = byte_index + BW'(1);
    end
  end

  // Content length that follows the name terminator, saturated.
  always_comb begin
    name_end    = (BW+1)'(name_len_next) + (BW+1)'(4);
    content_raw = {1'b0, byte_index_next} - name_end;
    content_len = 11'd0;
    if (closed_next && ({1'b0, byte_index_next} >= name_end)) begin
      if (content_raw > (BW+1)'(0) && content_raw >= (BW+1)'(CONTENT_SAT)) begin
        content_len = CONTENT_SAT;
      end else begin
        content_len = 11'(content_raw);
      end
    end
  end

  // Classification at the datagram's last byte.
  always_comb begin
    cls                = '0;
    cls.msg_type       = type_next;
    cls.ref_id         = ref_next;
    cls.pending_count  = 5'(fill);
    cls.action         = ACT_UNKNOWN;
    case (type_next)
      T_CONFIRM: begin
        cls.action = ACT_CONFIRM_MISS;
      end
      T_REPLY: begin
        cls.action       = (reply_next == REPLY_OK) ? ACT_REPLY_OK : ACT_REPLY_FAIL;
        cls.send_confirm = 1'b1;
      end
      T_ERR: begin
        cls.action       = ACT_ERR;
        cls.send_confirm = 1'b1;
        cls.quit         = 1'b1;
      end
      T_BYE: begin
        cls.action       = ACT_BYE;
        cls.send_confirm = 1'b1;
        cls.quit         = 1'b1;
      end
      T_MSG: begin
        cls.send_confirm = 1'b1;
        if (byte_index_next < BW'(3)) begin
          cls.action = ACT_TOO_SHORT;
        end else begin
          cls.name_length = name_len_next;
          if (nfault_next || (!closed_next && name_len_next >= max_name)) begin
            cls.action = ACT_BAD_NAME;
          end else begin
            cls.body_length = content_len;
            if (content_len > max_content) begin
              cls.action = ACT_TOO_LONG;
            end else if (cfault_next) begin
              cls.action = ACT_BAD_CONTENT;
            end else begin
              cls.action = ACT_MSG_OK;
            end
          end
        end
        if (cls.action != ACT_MSG_OK) begin
          cls.send_error = 1'b1;
          cls.quit       = 1'b1;
        end
      end
      default: begin
        cls.action     = ACT_UNKNOWN;
        cls.send_error = 1'b1;
        cls.quit       = 1'b1;
      end
    endcase
  end

  // Search result with the queue fill after any removal.
  always_comb begin
    emit_res               = res;
    emit_res.pending_count = 5'(fill);
  end

  // Single port pair of the pending queue: append, or move one entry down.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[IW-1:0];
    wr_data = item.sent_id;
    if (state == S_SWRITE) begin
      wr_en   = 1'b1;
      wr_addr = idx[IW-1:0];
      wr_data = rd_data;
    end else if (state == S_IDLE && accept && item.mode && fill < CW'(QUEUE_DEPTH)) begin
      wr_en = 1'b1;
    end
    rd_addr = (state == S_SREAD) ? idx_inc[IW-1:0] : idx[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pending_ids[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= pending_ids[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_name    <= MAX_NAME_RESET;
      max_content <= MAX_CONTENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_NAME:    max_name    <= cfg_data[4:0];
        REG_MAX_CONTENT: max_content <= cfg_data;
      endcase
    end
  end

  // Sequencer, datagram state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      idx          <= '0;
      byte_index   <= '0;
      type_reg     <= '0;
      ref_reg      <= '0;
      reply_result <= '0;
      name_len_reg <= '0;
      f_closed     <= 1'b0;
      f_nfault     <= 1'b0;
      f_cfault     <= 1'b0;
      f_cended     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !result_load) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && item.mode) begin
            if (fill < CW'(QUEUE_DEPTH)) begin
              fill <= fill + CW'(1);
            end
          end else if (accept) begin
            if (item.last_byte) begin
              byte_index   <= '0;
              type_reg     <= '0;
              ref_reg      <= '0;
              reply_result <= '0;
              name_len_reg <= '0;
              f_closed     <= 1'b0;
              f_nfault     <= 1'b0;
              f_cfault     <= 1'b0;
              f_cended     <= 1'b0;
              if (type_next == T_CONFIRM) begin
                res   <= cls;
                idx   <= '0;
                state <= S_READ;
              end else begin
                result       <= cls;
                result_valid <= 1'b1;
              end
            end else begin
              byte_index   <= byte_index_next;
              type_reg     <= type_next;
              ref_reg      <= ref_next;
              reply_result <= reply_next;
              name_len_reg <= name_len_next;
              f_closed     <= closed_next;
              f_nfault     <= nfault_next;
              f_cfault     <= cfault_next;
              f_cended     <= cended_next;
            end
          end
        end
        S_READ: begin
          if (idx >= fill) begin
            res.action <= ACT_CONFIRM_MISS;
            state      <= S_EMIT;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_data == res.ref_id) begin
            state <= S_SREAD;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_READ;
          end
        end
        S_SREAD: begin
          if (idx_inc < {1'b0, fill}) begin
            state <= S_SWRITE;
          end else begin
            fill       <= fill - CW'(1);
            res.action <= ACT_CONFIRM_OK;
            state      <= S_EMIT;
          end
        end
        S_SWRITE: begin
          idx   <= idx + CW'(1);
          state <= S_SREAD;
        end
        S_EMIT: begin
          if (out_free) begin
            result       <= emit_res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The queue never holds more IDs than it has entries.
  assert property (@(posedge clk) disable iff (rst) fill <= CW'(QUEUE_DEPTH))
    else $error("pending queue overfilled");

  // The fill moves by at most one per cycle.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ({1'b0, fill} == {1'b0, $past(fill)} ||
                     {1'b0, fill} == {1'b0, $past(fill)} + (CW+1)'(1) ||
                     {1'b0, fill} + (CW+1)'(1) == {1'b0, $past(fill)}))
    else $error("pending fill jumped");

  // An ID leaves the queue only at the end of a matched removal.
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fill < $past(fill)) |-> ($past(state) == S_SREAD && state == S_EMIT))
    else $error("pending fill dropped outside a removal");

  // While a search runs no new result appears.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP || state == S_SREAD || state == S_SWRITE) |=> !$rose(result_valid))
    else $error("result issued during queue search");

endmodule

### tb/datagram_chat_receive_classifier_checker.sv
`timescale 1ns / 1ps
module datagram_chat_receive_classifier_checker
  import dcrc_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QueueDepthDefault,
  parameter int MAX_DATAGRAM = MaxDatagramDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_stall,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_stall,
  input  result_t     result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  output int          fail_count,
  output int          results_due,
  output int          results_seen
);

  // Configuration as last written.
  logic [4:0]  name_limit;
  logic [10:0] content_limit;

  // Datagram in progress.
  int unsigned dgram_len;
  logic [7:0]  dgram_type;
  logic [15:0] dgram_ref;
  logic [7:0]  reply_status;
  int unsigned name_len;
  bit          name_closed;
  bit          name_fault;
  bit          content_fault;
  bit          content_ended;

  // Sent IDs awaiting confirmation, oldest first.
  logic [15:0] open_ids[$];

  // Classifications predicted but not yet seen on the output.
  result_t verdicts_due[$];

  int fails;
  int seen;

  function automatic bit is_text(logic [7:0] b);
    return b >= CHAR_LOW && b <= CHAR_HIGH;
  endfunction

  function automatic void clear_datagram();
    dgram_len     = 0;
    dgram_type    = '0;
    dgram_ref     = '0;
    reply_status  = '0;
    name_len      = 0;
    name_closed   = 1'b0;
    name_fault    = 1'b0;
    content_fault = 1'b0;
    content_ended = 1'b0;
  endfunction

  function automatic bit field_differs(string fname, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Update the prediction with one accepted item; a last byte yields a classification.
  function automatic void classify_item(item_t it);
    result_t     r;
    action_t     act;
    int          idx;
    int unsigned clen;
    logic [7:0]  b;
    b = it.data_byte;
    if (it.mode) begin
      // A registration is appended while there is room, otherwise dropped.
      if (open_ids.size() < QUEUE_DEPTH) open_ids.push_back(it.sent_id);
      return;
    end

    // Bytes past the size limit are ignored, but the last flag still counts.
    if (dgram_len < MAX_DATAGRAM) begin
      if (dgram_len == 0) dgram_type = b;
      else if (dgram_len == 1) dgram_ref = {b, 8'h00};
      else if (dgram_len == 2) dgram_ref[7:0] = b;
      else if (dgram_len == 3) reply_status = b;
      if (dgram_len >= 3 && dgram_type == T_MSG) begin
        if (!name_closed) begin
          if (b == 8'h00) begin
            name_closed = 1'b1;
          end else if (name_len >= name_limit) begin
            name_closed = 1'b1;
            name_fault  = 1'b1;
          end else begin
            if (!is_text(b)) name_fault = 1'b1;
            name_len++;
          end
        end else if (!content_fault && !content_ended) begin
          if (b == 8'h00) content_ended = 1'b1;
          else if (!is_text(b)) content_fault = 1'b1;
        end
      end
      dgram_len++;
    end
    if (!it.last_byte) return;

    r = '0;
    r.msg_type = dgram_type;
    r.ref_id   = dgram_ref;
    case (dgram_type)
      T_CONFIRM: begin
        // The first matching pending ID is removed.
        idx = -1;
        for (int i = 0; i < open_ids.size(); i++) begin
          if (idx < 0 && open_ids[i] == dgram_ref) idx = i;
        end
        if (idx >= 0) begin
          open_ids.delete(idx);
          act = ACT_CONFIRM_OK;
        end else begin
          act = ACT_CONFIRM_MISS;
        end
      end
      T_REPLY: begin
        act = (reply_status == REPLY_OK) ? ACT_REPLY_OK : ACT_REPLY_FAIL;
        r.send_confirm = 1'b1;
      end
      T_ERR: begin
        act = ACT_ERR;
        r.send_confirm = 1'b1;
        r.quit = 1'b1;
      end
      T_BYE: begin
        act = ACT_BYE;
        r.send_confirm = 1'b1;
        r.quit = 1'b1;
      end
      T_MSG: begin
        // Checks run in order: length, name, content size, content characters.
        r.send_confirm = 1'b1;
        if (dgram_len < 3) begin
          act = ACT_TOO_SHORT;
        end else begin
          r.name_length = 5'(name_len);
          if (name_fault || (!name_closed && name_len >= name_limit)) begin
            act = ACT_BAD_NAME;
          end else begin
            clen = 0;
            if (name_closed && dgram_len >= 4 + name_len) clen = dgram_len - 4 - name_len;
            if (clen > CONTENT_SAT) clen = CONTENT_SAT;
            r.body_length = 11'(clen);
            if (clen > content_limit) act = ACT_TOO_LONG;
            else if (content_fault) act = ACT_BAD_CONTENT;
            else act = ACT_MSG_OK;
          end
        end
        if (act != ACT_MSG_OK) begin
          r.send_error = 1'b1;
          r.quit = 1'b1;
        end
      end
      default: begin
        act = ACT_UNKNOWN;
        r.send_error = 1'b1;
        r.quit = 1'b1;
      end
    endcase
    r.action = act;
    r.pending_count = 5'(open_ids.size());
    verdicts_due.push_back(r);
    clear_datagram();
  endfunction

  // Watch both channels and the configuration port at each rising edge.
  always @(posedge clk) begin : watch
    result_t want;
    bit      bad;
    if (rst) begin
      name_limit    = MAX_NAME_RESET;
      content_limit = MAX_CONTENT_RESET;
      clear_datagram();
      open_ids.delete();
      verdicts_due.delete();
      fails = 0;
      seen  = 0;
    end else begin
      // A result is compared with the oldest expectation.
      if (result_valid && !result_stall) begin
        seen++;
        if (verdicts_due.size() == 0) begin
          $error("unexpected result: msg_type %0d action %0d", result.msg_type, result.action);
          fails++;
        end else begin
          want = verdicts_due.pop_front();
          bad  = 1'b0;
          bad |= field_differs("msg_type", 16'(want.msg_type), 16'(result.msg_type));
          bad |= field_differs("ref_id", want.ref_id, result.ref_id);
          bad |= field_differs("action", 16'(want.action), 16'(result.action));
          bad |= field_differs("send_confirm", 16'(want.send_confirm),
                               16'(result.send_confirm));
          bad |= field_differs("send_error", 16'(want.send_error), 16'(result.send_error));
          bad |= field_differs("quit", 16'(want.quit), 16'(result.quit));
          bad |= field_differs("pending_count", 16'(want.pending_count),
                               16'(result.pending_count));
          bad |= field_differs("name_length", 16'(want.name_length),
                               16'(result.name_length));
          bad |= field_differs("body_length", 16'(want.body_length),
                               16'(result.body_length));
          if (bad) fails++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_MAX_NAME) name_limit = cfg_data[4:0];
        else content_limit = cfg_data;
      end
      if (item_valid && !item_stall) classify_item(item);
    end
    fail_count   <= fails;
    results_due  <= verdicts_due.size();
    results_seen <= seen;
  end

endmodule

### tb/datagram_chat_receive_classifier_tb.sv
`timescale 1ns / 1ps
module datagram_chat_receive_classifier_tb;
  import dcrc_pkg::*;

  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 4 * QueueDepthDefault + 8;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  item_t       item_in      = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result_out;
  logic        cfg_we       = 1'b0;
  logic        cfg_index    = 1'b0;
  logic [10:0] cfg_data     = '0;

  int fail_count;
  int results_due;
  int results_seen;

  // Stimulus controls.
  int   send_idle_pct   = 0;
  int   stall_pct       = 0;
  int   reg_pct         = 0;
  logic hold_req        = 1'b0;
  int   hold_left       = 0;
  int   cur_name_max    = int'(MAX_NAME_RESET);
  int   cur_content_max = int'(MAX_CONTENT_RESET);
  int   items_sent      = 0;
  int   settings_used   = 1;

  logic [15:0] id_pool[8];
  logic [7:0]  dgram[$];

  datagram_chat_receive_classifier u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  datagram_chat_receive_classifier_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_due  (results_due),
    .results_seen (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: random stalls, or a long hold-off counted here on request.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      result_stall <= 1'b1;
      hold_left <= HoldCycles;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #10ms;
    $display("datagram_chat_receive_classifier: mismatch");
    $finish;
  end

  function automatic logic [7:0] text_byte();
    return 8'($urandom_range(CHAR_HIGH, CHAR_LOW));
  endfunction

  function automatic logic [7:0] bad_byte();
    return $urandom_range(1) ? 8'($urandom_range(8'h1F, 8'h01)) : 8'($urandom_range(8'hFF, 8'h7F));
  endfunction

  // Mostly IDs from a small pool so that confirms find matches.
  function automatic logic [15:0] pick_id();
    return ($urandom_range(3) != 0) ? id_pool[$urandom_range(7)] : 16'($urandom);
  endfunction

  // Build one random datagram into dgram.
  function automatic void build_dgram();
    int          kind;
    int          shape;
    int          nlen;
    int          clen;
    int          cap;
    int          spot;
    int          cstart;
    int          cut;
    logic [7:0]  t;
    logic [15:0] rid;
    dgram.delete();
    kind = $urandom_range(99);
    if (kind < 18) t = T_CONFIRM;
    else if (kind < 32) t = T_REPLY;
    else if (kind < 72) t = T_MSG;
    else if (kind < 78) t = T_ERR;
    else if (kind < 84) t = T_BYE;
    else begin
      do t = 8'($urandom_range(255));
      while (t == T_CONFIRM || t == T_REPLY || t == T_MSG || t == T_ERR || t == T_BYE);
    end
    rid = (t == T_CONFIRM) ? pick_id() : 16'($urandom);
    dgram.push_back(t);
    dgram.push_back(rid[15:8]);
    dgram.push_back(rid[7:0]);

    case (t)
      T_REPLY: begin
        dgram.push_back($urandom_range(1) ? REPLY_OK : 8'($urandom_range(255)));
        repeat ($urandom_range(3)) dgram.push_back(8'($urandom_range(255)));
      end
      T_MSG: begin
        // Name shapes: good, bad character, full then non-NUL, cut by the end, empty.
        shape = $urandom_range(9);
        nlen = $urandom_range(cur_name_max);
        if (shape == 9) nlen = 0;
        if (shape == 7) nlen = cur_name_max;
        if (shape == 6 && nlen == 0) nlen = 1;
        spot = (shape == 6) ? $urandom_range(nlen - 1) : -1;
        for (int i = 0; i < nlen; i++) dgram.push_back((i == spot) ? bad_byte() : text_byte());
        if (shape != 8) begin
          dgram.push_back((shape == 7) ? text_byte() : 8'h00);
          cap = (cur_content_max + 2 < 40) ? cur_content_max + 2 : 40;
          kind = $urandom_range(99);
          if (kind < 70) clen = $urandom_range(cap);
          else if (kind < 90 && cur_content_max <= 120) clen = cur_content_max - 1 + $urandom_range(3);
          else clen = $urandom_range(120);
          cstart = dgram.size();
          for (int i = 0; i < clen; i++) dgram.push_back(text_byte());
          if (clen > 0 && $urandom_range(99) < 15)
            dgram[cstart + $urandom_range(clen - 1)] = bad_byte();
          // A NUL ends the checked content; anything may follow it.
          if (clen > 0 && $urandom_range(99) < 20) begin
            spot = cstart + $urandom_range(clen - 1);
            dgram[spot] = 8'h00;
            for (int i = spot + 1; i < dgram.size(); i++)
              if ($urandom_range(2) == 0) dgram[i] = 8'($urandom_range(255));
          end
        end
      end
      default: begin
        repeat ($urandom_range(4)) dgram.push_back(8'($urandom_range(255)));
      end
    endcase

    // Now and then a datagram is cut short inside the header.
    if ($urandom_range(99) < 8) begin
      cut = 1 + $urandom_range(1);
      while (dgram.size() > cut) void'(dgram.pop_back());
    end
  endfunction

  // Offer one item, after a random idle gap, and hold it until it is taken.
  task automatic offer_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_in <= it;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic register_id(logic [15:0] id);
    item_t it;
    it.mode = 1'b1;
    it.data_byte = 8'($urandom);
    it.last_byte = 1'($urandom);
    it.sent_id = id;
    offer_item(it);
  endtask

  // Send dgram byte by byte, with the odd registration slipped in between.
  task automatic send_dgram();
    item_t it;
    for (int i = 0; i < dgram.size(); i++) begin
      if (reg_pct != 0 && $urandom_range(99) < 4) register_id(pick_id());
      it.mode = 1'b0;
      it.data_byte = dgram[i];
      it.last_byte = (i == dgram.size() - 1);
      it.sent_id = 16'($urandom);
      offer_item(it);
    end
  endtask

  // Wait until every expected result is in and the block has gone quiet.
  task automatic settle();
    item_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Drive one register write for a cycle; the caller drops the enable afterwards.
  task automatic write_cfg(logic idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 11'(val);
    @(posedge clk);
    if (idx == REG_MAX_NAME) cur_name_max = val;
    else cur_content_max = val;
  endtask

  // One phase: new settings, idle rates, then random datagrams up to a quota.
  task automatic run_phase(int nm, int cm, int idle, int stall, int regp, int quota, bit hold);
    int start;
    settle();
    write_cfg(REG_MAX_NAME, nm);
    write_cfg(REG_MAX_CONTENT, cm);
    cfg_we <= 1'b0;
    settings_used++;
    send_idle_pct = idle;
    reg_pct = regp;
    stall_pct <= stall;
    start = items_sent;
    if (hold) begin
      // Hold the output off while short datagrams keep coming, so the block backs up.
      hold_req <= 1'b1;
      @(posedge clk);
      hold_req <= 1'b0;
      repeat (60) begin
        dgram.delete();
        dgram.push_back($urandom_range(1) ? T_BYE : T_REPLY);
        send_dgram();
      end
    end
    while (items_sent - start < quota) begin
      if ($urandom_range(99) < reg_pct) register_id(pick_id());
      build_dgram();
      send_dgram();
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom);
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: each message type, short datagrams, extreme bytes and IDs.
    register_id(16'hFFFF);
    register_id(16'h0000);
    dgram = '{T_CONFIRM, 8'hFF, 8'hFF};
    send_dgram();
    dgram = '{T_CONFIRM, 8'h12, 8'h34};
    send_dgram();
    dgram = '{T_REPLY, 8'h00, 8'h00, REPLY_OK};
    send_dgram();
    dgram = '{T_REPLY};
    send_dgram();
    dgram = '{T_MSG, 8'hAB};
    send_dgram();
    dgram = '{T_MSG, 8'h00, 8'h01, 8'h41, 8'h00, CHAR_HIGH};
    send_dgram();
    dgram = '{T_ERR};
    send_dgram();
    dgram = '{T_BYE};
    send_dgram();
    dgram = '{8'h80};
    send_dgram();

    // Random phases across settings and idle patterns.
    run_phase(1, 1, 0, 0, 10, 160, 1'b0);
    run_phase(20, 2047, 49, 0, 10, 160, 1'b0);
    run_phase(5, 10, 0, 49, 25, 160, 1'b0);
    run_phase(12, 60, 17, 17, 10, 160, 1'b0);
    run_phase(8, 20, 0, 0, 10, 120, 1'b1);
    run_phase(3, 30, 0, 0, 30, 160, 1'b0);
    run_phase($urandom_range(20, 1), $urandom_range(2047, 1), 17, 17, 10, 160, 1'b0);
    run_phase(20, 1400, 49, 0, 10, 160, 1'b0);

    settle();
    $display("Run covered %0d items and %0d results under %0d register settings,",
             items_sent, results_seen, settings_used);
    $display("with idle and stall mixes and a long output hold.");
    if (results_due != 0) $error("%0d expected results never arrived", results_due);
    if (fail_count == 0 && results_due == 0) begin
      $display("datagram_chat_receive_classifier: match");
    end else begin
      $display("datagram_chat_receive_classifier: mismatch");
    end
    $finish;
  end

endmodule

### datagram_chat_receive_classifier.f
hdl/dcrc_pkg.sv
hdl/datagram_chat_receive_classifier.sv
tb/datagram_chat_receive_classifier_checker.sv
tb/datagram_chat_receive_classifier_tb.sv
